@@ rtl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants for the ADSR envelope shaper: segment codes and the
// configuration register map.
// ----------------------------------------------------------------------------
package aes_pkg;

   // Envelope segment codes, carried down the pipeline with each beat
   localparam int SEG_W = 3;
   localparam logic [SEG_W-1:0] SEG_ATTACK  = 3'd0;
   localparam logic [SEG_W-1:0] SEG_DECAY   = 3'd1;
   localparam logic [SEG_W-1:0] SEG_HOLD    = 3'd2;
   localparam logic [SEG_W-1:0] SEG_RELEASE = 3'd3;
   localparam logic [SEG_W-1:0] SEG_ZERO    = 3'd4;

   // Configuration register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_LEN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN_LEVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_START = 2'd3;

endpackage

@@ rtl/adsr_envelope_shaper.sv @@
// Pipeline from start to rsp_valid:
//   one input stage, one segment-select stage, one multiply stage,
//   FRAC_BITS+1 divider stages (one quotient bit each), one output stage.
// Throughput: one time position per cycle; busy is high only during reset.
// Reset: synchronous; clears the pipeline valids and loads the default
//   attack, decay, sustain and release registers. No result stall exists.
// ----------------------------------------------------------------------------
// adsr_envelope_shaper
// ADSR envelope level at a normalized time position: segment select, one
// multiply and a pipelined divide per beat.
// ----------------------------------------------------------------------------
module adsr_envelope_shaper #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [FRAC_BITS:0]            req_time_pos,
   output logic                          rsp_valid,
   output logic [FRAC_BITS:0]            rsp_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [FRAC_BITS:0]            csr_wdata
);

   import aes_pkg::*;

   localparam int W     = FRAC_BITS + 1;
   localparam int NW    = 2 * FRAC_BITS + 1;
   localparam int TAG_W = SEG_W + W;

   localparam logic [W-1:0] ONE         = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [W-1:0] ATTACK_RST  = W'(((2 ** FRAC_BITS) + 5) / 10);
   localparam logic [W-1:0] DECAY_RST   = W'(((2 ** FRAC_BITS) + 5) / 10);
   localparam logic [W-1:0] SUSTAIN_RST = W'((7 * (2 ** FRAC_BITS) + 5) / 10);
   localparam logic [W-1:0] RELEASE_RST = W'((8 * (2 ** FRAC_BITS) + 5) / 10);

   // configuration registers
   logic [W-1:0] attack_ff, decay_ff, sustain_ff, release_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ATTACK_RST;
         decay_ff   <= DECAY_RST;
         sustain_ff <= SUSTAIN_RST;
         release_ff <= RELEASE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ATTACK_LEN:    attack_ff  <= csr_wdata;
            REG_DECAY_LEN:     decay_ff   <= csr_wdata;
            REG_SUSTAIN_LEVEL: sustain_ff <= csr_wdata;
            REG_RELEASE_START: release_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // registers above full scale act as full scale
   logic [W-1:0] a_sat, d_sat, s_sat, r_sat;

   assign a_sat = (attack_ff  > ONE) ? ONE : attack_ff;
   assign d_sat = (decay_ff   > ONE) ? ONE : decay_ff;
   assign s_sat = (sustain_ff > ONE) ? ONE : sustain_ff;
   assign r_sat = (release_ff > ONE) ? ONE : release_ff;

   // stage A: input capture
   logic         va_ff;
   logic [W-1:0] ta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      ta_ff <= req_time_pos;
   end

   // stage B: segment select and multiplier/divider operands
   logic             vb_ff;
   logic [SEG_W-1:0] seg_b_ff, seg_b_in;
   logic [W-1:0]     opa_b_ff, opa_b_in;
   logic [W-1:0]     opb_b_ff, opb_b_in;
   logic [W-1:0]     den_b_ff, den_b_in;
   logic [W-1:0]     sus_b_ff;
   logic [W-1:0]     diff_ta;

   always_comb begin
      diff_ta  = ta_ff - a_sat;
      seg_b_in = SEG_ZERO;
      opa_b_in = '0;
      opb_b_in = '0;
      den_b_in = ONE;
      if (ta_ff < a_sat) begin
         seg_b_in = SEG_ATTACK;
         opa_b_in = ta_ff;
         opb_b_in = ONE;
         den_b_in = a_sat;
      end else if (diff_ta < d_sat) begin
         seg_b_in = SEG_DECAY;
         opa_b_in = ONE - s_sat;
         opb_b_in = diff_ta;
         den_b_in = d_sat;
      end else if (ta_ff < r_sat) begin
         seg_b_in = SEG_HOLD;
      end else if (ta_ff < ONE) begin
         seg_b_in = SEG_RELEASE;
         opa_b_in = s_sat;
         opb_b_in = ONE - ta_ff;
         den_b_in = ONE - r_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      seg_b_ff <= seg_b_in;
      opa_b_ff <= opa_b_in;
      opb_b_ff <= opb_b_in;
      den_b_ff <= den_b_in;
      sus_b_ff <= s_sat;
   end

   // stage C: numerator product, never above 2^(2*FRAC_BITS)
   logic             vc_ff;
   logic [NW-1:0]    num_c_ff;
   logic [W-1:0]     den_c_ff;
   logic [TAG_W-1:0] tag_c_ff;
   logic [2*W-1:0]   prod;

   assign prod = opa_b_ff * opb_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_c_ff <= prod[NW-1:0];
      den_c_ff <= den_b_ff;
      tag_c_ff <= {seg_b_ff, sus_b_ff};
   end

   // divide pipeline
   logic             div_valid;
   logic [W-1:0]     div_quo;
   logic [TAG_W-1:0] div_tag;

   aes_div #(
      .FRAC_BITS (FRAC_BITS),
      .TAG_W     (TAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc_ff),
      .in_num    (num_c_ff),
      .in_den    (den_c_ff),
      .in_tag    (tag_c_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // output stage: map quotient to level by segment
   logic             rsp_valid_ff;
   logic [W-1:0]     rsp_level_ff, level_in;
   logic [SEG_W-1:0] seg_o;
   logic [W-1:0]     sus_o;

   assign seg_o = div_tag[TAG_W-1:W];
   assign sus_o = div_tag[W-1:0];

   always_comb begin
      case (seg_o)
         SEG_ATTACK:  level_in = div_quo;
         SEG_DECAY:   level_in = ONE - div_quo;
         SEG_HOLD:    level_in = sus_o;
         SEG_RELEASE: level_in = div_quo;
         default:     level_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= level_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

endmodule

@@ rtl/aes_div.sv @@
// ----------------------------------------------------------------------------
// aes_div
// Pipelined restoring divider, one quotient bit per stage. The numerator is
// known to give a quotient of FRAC_BITS+1 bits at most, so the upper bits
// seed the partial remainder. A tag rides along with each beat.
// ----------------------------------------------------------------------------
module aes_div #(
   parameter int FRAC_BITS = 16,
   parameter int TAG_W     = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [2*FRAC_BITS:0]   in_num,
   input  logic [FRAC_BITS:0]     in_den,
   input  logic [TAG_W-1:0]       in_tag,
   output logic                   out_valid,
   output logic [FRAC_BITS:0]     out_quo,
   output logic [TAG_W-1:0]       out_tag
);

   localparam int W      = FRAC_BITS + 1;
   localparam int NW     = 2 * FRAC_BITS + 1;
   localparam int STAGES = W;

   // per-stage pipeline registers
   logic                 vld_ff [STAGES];
   logic [FRAC_BITS-1:0] rem_ff [STAGES];
   logic [W-1:0]         nq_ff  [STAGES];   // numerator bits out the top, quotient in
   logic [W-1:0]         den_ff [STAGES];
   logic [TAG_W-1:0]     tag_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_step
      logic                 vld_src;
      logic [FRAC_BITS-1:0] rem_src;
      logic [W-1:0]         nq_src;
      logic [W-1:0]         den_src;
      logic [TAG_W-1:0]     tag_src;
      logic [W-1:0]         trial;
      logic [W-1:0]         diff;
      logic                 ge;
      logic [FRAC_BITS-1:0] rem_in;
      logic [W-1:0]         nq_in;

      // stage source: the input port for the first step, else the prior stage
      if (k == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = in_num[NW-1:W];
         assign nq_src  = in_num[W-1:0];
         assign den_src = in_den;
         assign tag_src = in_tag;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign nq_src  = nq_ff[k-1];
         assign den_src = den_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      // one restoring step: shift in next bit, subtract if it fits
      always_comb begin
         trial  = {rem_src, nq_src[W-1]};
         ge     = (trial >= den_src);
         diff   = trial - den_src;
         rem_in = ge ? diff[FRAC_BITS-1:0] : trial[FRAC_BITS-1:0];
         nq_in  = {nq_src[W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         nq_ff[k]  <= nq_in;
         den_ff[k] <= den_src;
         tag_ff[k] <= tag_src;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quo   = nq_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];

endmodule

@@ tb/adsr_envelope_shaper_tb.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_shaper_tb
// Drives time positions into the envelope shaper and checks every level
// that comes back against an in-bench envelope calculator. The run covers
// reset defaults, each segment boundary, zero-length and saturated segments,
// then random envelope settings with positions clustered on the boundaries.
// ----------------------------------------------------------------------------
module adsr_envelope_shaper_tb;

   import aes_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int W = FRAC_BITS + 1;
   localparam logic [63:0] LVL_ONE = 64'd1 << FRAC_BITS;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BEATS = 50;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [W-1:0] time_pos;
      logic [W-1:0] level;
   } level_beat_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [W-1:0]         req_time_pos;
   logic                 rsp_valid;
   logic [W-1:0]         rsp_level;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [W-1:0]         csr_wdata;

   // Envelope settings as the bench believes them to be
   logic [W-1:0] env_attack;
   logic [W-1:0] env_decay;
   logic [W-1:0] env_sustain;
   logic [W-1:0] env_release;

   level_beat_type pending_levels[$];
   int             err_count;

   adsr_envelope_shaper #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_time_pos (req_time_pos),
      .rsp_valid    (rsp_valid),
      .rsp_level    (rsp_level),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Envelope level for one time position under the current settings
   function automatic logic [W-1:0] envelope_level(input logic [W-1:0] t_in);
      logic [63:0] t, a, d, s, r, lv;
      t = 64'(t_in);
      a = (64'(env_attack)  > LVL_ONE) ? LVL_ONE : 64'(env_attack);
      d = (64'(env_decay)   > LVL_ONE) ? LVL_ONE : 64'(env_decay);
      s = (64'(env_sustain) > LVL_ONE) ? LVL_ONE : 64'(env_sustain);
      r = (64'(env_release) > LVL_ONE) ? LVL_ONE : 64'(env_release);
      if (t < a) begin
         lv = (t << FRAC_BITS) / a;
      end else if (t - a < d) begin
         lv = LVL_ONE - ((LVL_ONE - s) * (t - a)) / d;
      end else if (t < r) begin
         lv = s;
      end else if (t < LVL_ONE) begin
         // r <= t < ONE here, divisor is nonzero
         lv = (s * (LVL_ONE - t)) / (LVL_ONE - r);
      end else begin
         lv = 64'd0;
      end
      if (lv > LVL_ONE)
         lv = LVL_ONE;
      return lv[W-1:0];
   endfunction

   // Result checker: every strobed level is matched against the oldest pending
   always @(posedge clock) begin
      level_beat_type exp_beat;
      if (!reset && rsp_valid) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected level beat, expected none, actual %0d",
                     $time, rsp_level);
            err_count++;
         end else begin
            exp_beat = pending_levels.pop_front();
            if (rsp_level !== exp_beat.level) begin
               $display("%0t: level mismatch at t=%0d, expected %0d, actual %0d",
                        $time, exp_beat.time_pos, exp_beat.level, rsp_level);
               err_count++;
            end
         end
      end
   end

   // One time position; start stays high on return
   task automatic send_pos(input logic [W-1:0] t);
      level_beat_type beat;
      start        <= 1'b1;
      req_time_pos <= t;
      do @(posedge clock); while (busy);
      beat.time_pos = t;
      beat.level    = envelope_level(t);
      pending_levels.push_back(beat);
   endtask

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   task automatic send_and_idle(input logic [W-1:0] t, input bit no_gaps);
      int gap;
      send_pos(t);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every pending level has come back
   task automatic wait_drain();
      start <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // csr_valid stays high on return so back-to-back writes need no toggle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ATTACK_LEN:    env_attack  = value;
         REG_DECAY_LEN:     env_decay   = value;
         REG_SUSTAIN_LEVEL: env_sustain = value;
         REG_RELEASE_START: env_release = value;
         default: ;
      endcase
   endtask

   // Full envelope rewrite, only called with the pipeline empty
   task automatic write_envelope(input logic [W-1:0] a, input logic [W-1:0] d,
                                 input logic [W-1:0] s, input logic [W-1:0] r);
      wait_drain();
      write_reg(REG_ATTACK_LEN, a);
      write_reg(REG_DECAY_LEN, d);
      write_reg(REG_SUSTAIN_LEVEL, s);
      write_reg(REG_RELEASE_START, r);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Register value with weight on the extremes and on saturation
   function automatic logic [W-1:0] pick_reg_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return W'(LVL_ONE);
         2: return W'($urandom_range(65537, 131071));
         3: return W'(1);
         default: return W'($urandom_range(0, 65536));
      endcase
   endfunction

   // Time position clustered on segment edges, with some uniform noise
   function automatic logic [W-1:0] pick_time_pos();
      logic [63:0] a, d, edge_pt;
      int roll;
      a = (64'(env_attack) > LVL_ONE) ? LVL_ONE : 64'(env_attack);
      d = (64'(env_decay)  > LVL_ONE) ? LVL_ONE : 64'(env_decay);
      roll = $urandom_range(0, 9);
      if (roll < 3)
         return W'($urandom_range(0, 131071));
      if (roll < 5)
         return W'($urandom_range(0, 65536));
      case ($urandom_range(0, 3))
         0: edge_pt = a;
         1: edge_pt = a + d;
         2: edge_pt = (64'(env_release) > LVL_ONE) ? LVL_ONE : 64'(env_release);
         default: edge_pt = LVL_ONE;
      endcase
      edge_pt = edge_pt + 64'($urandom_range(0, 4)) - 64'd2;
      return edge_pt[W-1:0];
   endfunction

   // ---------------------------------------------------------------- tests

   // Defaults after reset, every segment and its edges
   task automatic test_reset_defaults();
      logic [W-1:0] pts[$];
      pts = '{0, 1, 6553, 6554, 9830, 13107, 13108, 30000,
              52428, 52429, 65535, 65536, 131071};
      foreach (pts[i]) send_and_idle(pts[i], 1'b0);
   endtask

   // Zero attack: level starts at full scale
   task automatic test_zero_attack();
      write_envelope(0, 6554, 32768, 52429);
      send_and_idle(0, 1'b0);
      send_and_idle(1, 1'b0);
      send_and_idle(6554, 1'b0);
   endtask

   // Zero decay: straight from attack to sustain
   task automatic test_zero_decay();
      write_envelope(6554, 0, 32768, 52429);
      send_and_idle(6553, 1'b0);
      send_and_idle(6554, 1'b0);
      send_and_idle(6555, 1'b0);
   endtask

   // Release start set inside the decay: the decay runs to its end, then release, no hold
   task automatic test_release_before_decay_end();
      write_envelope(13107, 13107, 16384, 19660);
      send_and_idle(19660, 1'b0);
      send_and_idle(26213, 1'b0);
      send_and_idle(26214, 1'b0);
   endtask

   // Release start at the end of the note: sustain holds to the end
   task automatic test_release_at_end();
      write_envelope(6554, 6554, 40000, 65536);
      send_and_idle(65535, 1'b0);
      send_and_idle(65536, 1'b0);
   endtask

   // Registers above full scale are treated as full scale
   task automatic test_saturated_registers();
      write_envelope(131071, 70000, 131071, 100000);
      send_and_idle(65535, 1'b0);
      send_and_idle(65536, 1'b0);
      send_and_idle(131071, 1'b0);
   endtask

   // Random envelopes (the last phase a fixed full-scale attack and decay), positions mostly on the segment edges
   task automatic test_random_sweep();
      bit no_gaps;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1)
            write_envelope(W'(LVL_ONE), W'(LVL_ONE), 0, 0);
         else
            write_envelope(pick_reg_value(), pick_reg_value(),
                           pick_reg_value(), pick_reg_value());
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_BEATS; n++)
            send_and_idle(pick_time_pos(), no_gaps);
      end
   endtask

   initial begin
      err_count    = 0;
      env_attack   = 17'd6554;
      env_decay    = 17'd6554;
      env_sustain  = 17'd45875;
      env_release  = 17'd52429;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_time_pos <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= REG_ATTACK_LEN;
      csr_wdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_attack();
      test_zero_decay();
      test_release_before_decay_end();
      test_release_at_end();
      test_saturated_registers();
      test_random_sweep();

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_levels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/aes_pkg.sv
rtl/aes_div.sv
rtl/adsr_envelope_shaper.sv
tb/adsr_envelope_shaper_tb.sv
